[design/sem_pkg.sv]
`default_nettype none
package sem_pkg;

	localparam int MaxWidth  = 2048;
	localparam int MaxHeight = 4096;
	localparam int ColW      = $clog2(MaxWidth);
	localparam int RowW      = $clog2(MaxHeight);
	localparam int WidthW    = 12;
	localparam int HeightW   = 13;
	localparam int CfgIdxW   = 2;
	localparam int CfgDataW  = 13;
	localparam int JobDepth  = 4;
	localparam int OutDepth  = 4;
	localparam int SatLimit  = 65280;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] RegFrameWidth  = 2'd0;
	localparam logic [CfgIdxW-1:0] RegFrameHeight = 2'd1;

	// item commands
	localparam logic CmdPixel = 1'b0;
	localparam logic CmdDrain = 1'b1;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		pixel_t top;
		pixel_t mid;
		pixel_t bot;
	} column_t;

	typedef struct packed {
		column_t lft;
		column_t ctr;
		column_t rgt;
		logic    fend;
	} job_t;

	typedef struct packed {
		logic       command;
		logic [7:0] pixel_red;
		logic [7:0] pixel_green;
		logic [7:0] pixel_blue;
	} in_item_t;

	typedef struct packed {
		logic [7:0] edge_red;
		logic [7:0] edge_green;
		logic [7:0] edge_blue;
		logic       frame_end;
	} out_item_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_PIX,
		F_PIX_B,
		F_DRN0,
		F_DRN1,
		F_DRN2
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SQ,
		B_ROOT,
		B_DONE
	} back_state_t;

endpackage
`default_nettype wire

[design/sem_ram.sv]
`default_nettype none
module sem_ram #(
	parameter int Width = 24,
	parameter int Depth = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[design/sem_jobq.sv]
`default_nettype none
module sem_jobq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire sem_pkg::job_t push_data,
	input  wire logic          pop,
	output sem_pkg::job_t      head,
	output logic               avail,
	output logic               room2
);
	import sem_pkg::*;

	localparam int PtrW = $clog2(JobDepth);
	localparam int CntW = $clog2(JobDepth + 1);

	job_t            mem_q [JobDepth];
	logic [PtrW-1:0] wp_q;
	logic [PtrW-1:0] rp_q;
	logic [CntW-1:0] cnt_q;

	assign head  = mem_q[rp_q];
	assign avail = (cnt_q != '0);
	assign room2 = (cnt_q <= CntW'(JobDepth - 2));

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

endmodule
`default_nettype wire

[design/sem_front.sv]
`default_nettype none
module sem_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire sem_pkg::in_item_t              item,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [sem_pkg::CfgIdxW-1:0]    cfg_index,
	input  wire logic [sem_pkg::CfgDataW-1:0]   cfg_data,
	output logic                                job_push,
	output sem_pkg::job_t                       job,
	input  wire logic                           job_room
);
	import sem_pkg::*;

	front_state_t         state_q, state_d;
	logic [WidthW-1:0]    width_q;
	logic [HeightW-1:0]   height_q;
	logic [WidthW-1:0]    eff_w;
	logic [HeightW-1:0]   eff_h;
	logic [ColW-1:0]      col_q;
	logic [RowW-1:0]      row_q;
	logic [ColW-1:0]      drn_q;
	logic                 draining_q;
	logic                 has_top_q;
	column_t              win_q [2];
	pixel_t               px_q;
	job_t                 jobb_q;
	column_t              dcol0_q, dcol1_q;

	logic                 accept;
	logic [ColW-1:0]      rd_addr;
	pixel_t               older_rd, newer_rd;
	logic                 ram_we;

	column_t              cur;
	column_t              prev_ctr;
	job_t                 job_a, job_b;
	logic                 a_vld, b_vld;
	logic [WidthW-1:0]    col_next;
	logic [HeightW-1:0]   row_next;

	logic [WidthW-1:0]    dx;
	logic                 dok;
	column_t              dcol;
	logic                 dfend;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;
	assign full      = !((state_q == F_IDLE) && job_room);

	// clamp geometry to the legal range
	always_comb begin
		if (width_q == '0)                           eff_w = WidthW'(1);
		else if (width_q > WidthW'(MaxWidth))        eff_w = WidthW'(MaxWidth);
		else                                         eff_w = width_q;
		if (height_q == '0)                          eff_h = HeightW'(1);
		else if (height_q > HeightW'(MaxHeight))     eff_h = HeightW'(MaxHeight);
		else                                         eff_h = height_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WidthW'(640);
			height_q <= HeightW'(480);
		end else if (cfg_valid) begin
			if (cfg_index == RegFrameWidth)  width_q  <= cfg_data[WidthW-1:0];
			if (cfg_index == RegFrameHeight) height_q <= cfg_data;
		end
	end

	// line buffers
	sem_ram #(.Width($bits(pixel_t)), .Depth(MaxWidth)) u_older (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_q),
		.wdata (newer_rd),
		.raddr (rd_addr),
		.rdata (older_rd)
	);

	sem_ram #(.Width($bits(pixel_t)), .Depth(MaxWidth)) u_newer (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_q),
		.wdata (px_q),
		.raddr (rd_addr),
		.rdata (newer_rd)
	);

	assign ram_we = (state_q == F_PIX);

	// read address per state
	always_comb begin
		unique case (state_q)
			F_IDLE:  rd_addr = (item.command == CmdDrain) ? drn_q - 1'b1 : col_q;
			F_DRN0:  rd_addr = drn_q;
			F_DRN1:  rd_addr = drn_q + 1'b1;
			default: rd_addr = col_q;
		endcase
	end

	// pixel window: current column and the two result requests it can make
	always_comb begin
		cur.top  = (row_q >= RowW'(2)) ? older_rd : '0;
		cur.mid  = (row_q >= RowW'(1)) ? newer_rd : '0;
		cur.bot  = px_q;
		prev_ctr = (col_q == '0) ? '0 : win_q[1];
		job_a.lft  = win_q[0];
		job_a.ctr  = win_q[1];
		job_a.rgt  = cur;
		job_a.fend = 1'b0;
		job_b.lft  = prev_ctr;
		job_b.ctr  = cur;
		job_b.rgt  = '0;
		job_b.fend = 1'b0;
		col_next = {1'b0, col_q} + 1'b1;
		row_next = {1'b0, row_q} + 1'b1;
		a_vld = (row_q != '0) && (col_q != '0);
		b_vld = (row_q != '0) && (col_next >= eff_w);
	end

	// drain column for the read in flight
	always_comb begin
		unique case (state_q)
			F_DRN1:  dx = {1'b0, drn_q} + WidthW'(1);
			F_DRN2:  dx = {1'b0, drn_q} + WidthW'(2);
			default: dx = {1'b0, drn_q};
		endcase
		dok      = (dx != '0) && ((dx - 1'b1) < eff_w);
		dcol.top = (dok && has_top_q) ? older_rd : '0;
		dcol.mid = dok ? newer_rd : '0;
		dcol.bot = '0;
		dfend    = (({1'b0, drn_q} + 1'b1) >= eff_w);
	end

	// next state and job push
	always_comb begin
		state_d  = state_q;
		job_push = 1'b0;
		job      = job_a;
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					if (item.command == CmdPixel) state_d = F_PIX;
					else if (draining_q)          state_d = F_DRN0;
				end
			end
			F_PIX: begin
				job_push = a_vld || b_vld;
				job      = a_vld ? job_a : job_b;
				state_d  = (a_vld && b_vld) ? F_PIX_B : F_IDLE;
			end
			F_PIX_B: begin
				job_push = 1'b1;
				job      = jobb_q;
				state_d  = F_IDLE;
			end
			F_DRN0: state_d = F_DRN1;
			F_DRN1: state_d = F_DRN2;
			F_DRN2: begin
				job_push  = 1'b1;
				job.lft   = dcol0_q;
				job.ctr   = dcol1_q;
				job.rgt   = dcol;
				job.fend  = dfend;
				state_d   = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// frame position, drain progress and window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			drn_q      <= '0;
			draining_q <= 1'b0;
			has_top_q  <= 1'b0;
			win_q[0]   <= '0;
			win_q[1]   <= '0;
		end else begin
			if (accept && item.command == CmdPixel) begin
				draining_q <= 1'b0;
				drn_q      <= '0;
			end
			if (state_q == F_PIX) begin
				win_q[0] <= prev_ctr;
				win_q[1] <= cur;
				if (col_next >= eff_w) begin
					col_q <= '0;
					if (row_next >= eff_h) begin
						row_q      <= '0;
						has_top_q  <= (row_next >= HeightW'(2));
						draining_q <= 1'b1;
						drn_q      <= '0;
					end else begin
						row_q <= row_next[RowW-1:0];
					end
				end else begin
					col_q <= col_next[ColW-1:0];
				end
			end
			if (state_q == F_DRN2) begin
				if (dfend) begin
					draining_q <= 1'b0;
					drn_q      <= '0;
				end else begin
					drn_q <= drn_q + 1'b1;
				end
			end
		end
	end

	// payload holding registers
	always_ff @(posedge clk) begin
		if (accept) px_q <= {item.pixel_red, item.pixel_green, item.pixel_blue};
		if (state_q == F_PIX)  jobb_q  <= job_b;
		if (state_q == F_DRN0) dcol0_q <= dcol;
		if (state_q == F_DRN1) dcol1_q <= dcol;
	end

endmodule
`default_nettype wire

[design/sem_back.sv]
`default_nettype none
module sem_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sem_pkg::job_t      head,
	input  wire logic               avail,
	output logic                    job_pop,
	output logic                    empty,
	input  wire logic               pop,
	output sem_pkg::out_item_t      result
);
	import sem_pkg::*;

	localparam int PtrW = $clog2(OutDepth);
	localparam int CntW = $clog2(OutDepth + 1);

	back_state_t       state_q, state_d;
	logic [9:0]        ax_s1 [3];
	logic [9:0]        ay_s1 [3];
	logic [20:0]       sum_s2 [3];
	logic [7:0]        root_q [3];
	logic [2:0]        bit_q;
	logic              fend_s1;

	logic [2:0][7:0]   lt, lm, lb, ct, cb, rt, rm, rb;
	logic signed [10:0] gx [3];
	logic signed [10:0] gy [3];
	logic [10:0]       gxa [3];
	logic [10:0]       gya [3];
	logic [7:0]        trial [3];
	logic [7:0]        res [3];
	logic [16:0]       rsq [3];

	out_item_t         ofifo_q [OutDepth];
	logic [PtrW-1:0]   wp_q, rp_q;
	logic [CntW-1:0]   cnt_q;
	logic              opush, opop;

	function automatic logic signed [10:0] grad(input logic [7:0] p0, input logic [7:0] n0,
			input logic [7:0] p1, input logic [7:0] n1,
			input logic [7:0] p2, input logic [7:0] n2);
		logic signed [10:0] d0, d1, d2;
		d0 = $signed({3'b0, p0}) - $signed({3'b0, n0});
		d1 = $signed({3'b0, p1}) - $signed({3'b0, n1});
		d2 = $signed({3'b0, p2}) - $signed({3'b0, n2});
		return d0 + (d1 <<< 1) + d2;
	endfunction

	// Sobel gradients per channel, index 2 red, 1 green, 0 blue
	always_comb begin
		lt = head.lft.top; lm = head.lft.mid; lb = head.lft.bot;
		ct = head.ctr.top; cb = head.ctr.bot;
		rt = head.rgt.top; rm = head.rgt.mid; rb = head.rgt.bot;
		for (int ch = 0; ch < 3; ch++) begin
			gx[ch]  = grad(rt[ch], lt[ch], rm[ch], lm[ch], rb[ch], lb[ch]);
			gy[ch]  = grad(lb[ch], lt[ch], cb[ch], ct[ch], rb[ch], rt[ch]);
			gxa[ch] = gx[ch][10] ? 11'(-gx[ch]) : 11'(gx[ch]);
			gya[ch] = gy[ch][10] ? 11'(-gy[ch]) : 11'(gy[ch]);
		end
	end

	// root trial bit and final rounding
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			trial[ch] = root_q[ch] | (8'd1 << bit_q);
			rsq[ch]   = ({9'b0, root_q[ch]} * {9'b0, root_q[ch]}) + {9'b0, root_q[ch]};
			if (sum_s2[ch] > 21'(SatLimit))      res[ch] = 8'd255;
			else if (sum_s2[ch] > 21'(rsq[ch]))  res[ch] = root_q[ch] + 1'b1;
			else                                 res[ch] = root_q[ch];
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		job_pop = 1'b0;
		opush   = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (avail) begin
					job_pop = 1'b1;
					state_d = B_SQ;
				end
			end
			B_SQ:   state_d = B_ROOT;
			B_ROOT: if (bit_q == '0) state_d = B_DONE;
			B_DONE: begin
				if (cnt_q != CntW'(OutDepth)) begin
					opush   = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				for (int ch = 0; ch < 3; ch++) begin
					ax_s1[ch] <= gxa[ch][9:0];
					ay_s1[ch] <= gya[ch][9:0];
				end
				fend_s1 <= head.fend;
			end
			B_SQ: begin
				for (int ch = 0; ch < 3; ch++) begin
					sum_s2[ch] <= ({11'b0, ax_s1[ch]} * {11'b0, ax_s1[ch]})
						+ ({11'b0, ay_s1[ch]} * {11'b0, ay_s1[ch]});
					root_q[ch] <= '0;
				end
				bit_q <= 3'd7;
			end
			B_ROOT: begin
				for (int ch = 0; ch < 3; ch++) begin
					if (({13'b0, trial[ch]} * {13'b0, trial[ch]}) <= sum_s2[ch])
						root_q[ch] <= trial[ch];
				end
				bit_q <= bit_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	// result queue
	assign opop   = pop && (cnt_q != '0);
	assign empty  = (cnt_q == '0);
	assign result = ofifo_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (opush) wp_q <= wp_q + 1'b1;
			if (opop)  rp_q <= rp_q + 1'b1;
			if (opush && !opop)      cnt_q <= cnt_q + 1'b1;
			else if (opop && !opush) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (opush) ofifo_q[wp_q] <= {res[2], res[1], res[0], fend_s1};
	end

endmodule
`default_nettype wire

[design/sobel_edge_magnitude_rgb_core.sv]
`default_nettype none
// Streaming 3x3 Sobel edge magnitude on RGB pixels in raster order. Pixels
// outside the frame count as zero; each channel gives round(sqrt(gx^2+gy^2))
// saturated at 255. The result for a pixel appears once the pixel below-right
// of it is in; the last row comes out through drain items, one per item, with
// frame_end on the last. The front takes no new item until done with the last:
// a pixel passes F_PIX (and F_PIX_B at a row end, where it makes two requests),
// a drain F_DRN0 to F_DRN2, which read the line buffers. The back takes one
// result request at a time, through squaring and the 8-step square root. A
// 4-entry queue sits between the two halves; 4 results can wait at the output.
// Frame width and height take effect at once; write them between frames.
module sobel_edge_magnitude_rgb_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire sem_pkg::in_item_t             item,
	output logic                               empty,
	input  wire logic                          pop,
	output sem_pkg::out_item_t                 result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [sem_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [sem_pkg::CfgDataW-1:0]  cfg_data
);
	import sem_pkg::*;

	logic job_push, job_pop, job_avail, job_room;
	job_t job_in, job_head;

	sem_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.job_push  (job_push),
		.job       (job_in),
		.job_room  (job_room)
	);

	sem_jobq u_jobq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_in),
		.pop       (job_pop),
		.head      (job_head),
		.avail     (job_avail),
		.room2     (job_room)
	);

	sem_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (job_head),
		.avail   (job_avail),
		.job_pop (job_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule
`default_nettype wire

[sim/tb_sobel_edge_magnitude_rgb_core.sv]
`default_nettype none
module tb_sobel_edge_magnitude_rgb_core;
	import sem_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                push;
	logic                full;
	in_item_t            item;
	logic                empty;
	logic                pop;
	out_item_t           result;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	sobel_edge_magnitude_rgb_core uut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// expected edge results, oldest first
	out_item_t edge_queue[$];
	int        error_count;
	int        sent_items;

	// shadow of the block: geometry, line buffers, window and position
	logic [WidthW-1:0]  shadow_width;
	logic [HeightW-1:0] shadow_height;
	pixel_t             older_line[MaxWidth];
	pixel_t             newer_line[MaxWidth];
	column_t            win_prev;
	column_t            win_last;
	int                 row_pos;
	int                 col_pos;
	int                 drain_pos;
	bit                 draining;
	bit                 drain_top;

	// sender burst control
	int burst_left;
	bit no_gaps;

	// receiver hold-off request
	bit hold_request;
	int hold_left;
	int pop_phase;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * 2000000);
		$display("tb_sobel_edge_magnitude_rgb_core NOT OK");
		$finish;
	end

	function automatic int active_width();
		if (shadow_width == 0) return 1;
		if (shadow_width > MaxWidth) return MaxWidth;
		return shadow_width;
	endfunction

	function automatic int active_height();
		if (shadow_height == 0) return 1;
		if (shadow_height > MaxHeight) return MaxHeight;
		return shadow_height;
	endfunction

	// rounded square root, saturated at 255
	function automatic logic [7:0] rounded_root(int unsigned s);
		int unsigned r;
		if (s > SatLimit) return 8'd255;
		r = 0;
		while ((r + 1) * (r + 1) <= s) r++;
		if (s > r * r + r) r++;
		return (r > 255) ? 8'd255 : r[7:0];
	endfunction

	function automatic int channel_of(pixel_t p, int ch);
		case (ch)
			0: return p.red;
			1: return p.green;
			default: return p.blue;
		endcase
	endfunction

	function automatic pixel_t pixel_at(column_t c, int j);
		case (j)
			0: return c.top;
			1: return c.mid;
			default: return c.bot;
		endcase
	endfunction

	// Sobel magnitude of one 3x3 window, all three channels
	function automatic out_item_t sobel_magnitude(column_t lft, column_t ctr, column_t rgt,
		logic fend);
		out_item_t o;
		column_t   cols[3];
		int        wt[3];
		int        gx;
		int        gy;
		logic [7:0] mag[3];
		cols[0] = lft; cols[1] = ctr; cols[2] = rgt;
		wt[0] = 1; wt[1] = 2; wt[2] = 1;
		for (int ch = 0; ch < 3; ch++) begin
			gx = 0;
			gy = 0;
			for (int j = 0; j < 3; j++) begin
				gx += wt[j] * (channel_of(pixel_at(rgt, j), ch) - channel_of(pixel_at(lft, j), ch));
				gy += wt[j] * (channel_of(cols[j].bot, ch) - channel_of(cols[j].top, ch));
			end
			mag[ch] = rounded_root(gx * gx + gy * gy);
		end
		o.edge_red = mag[0];
		o.edge_green = mag[1];
		o.edge_blue = mag[2];
		o.frame_end = fend;
		return o;
	endfunction

	// advance the shadow by one accepted request and queue what it yields
	task automatic predict_edges(in_item_t it);
		column_t dcol[3];
		column_t cur;
		int      w;
		int      x;
		bit      ok;
		logic    fend;
		w = active_width();
		if (it.command == CmdDrain) begin
			if (draining) begin
				for (int k = 0; k < 3; k++) begin
					x = drain_pos + k;
					ok = (x >= 1) && (x - 1 < w);
					dcol[k] = '0;
					if (ok && drain_top) dcol[k].top = older_line[x - 1];
					if (ok) dcol[k].mid = newer_line[x - 1];
				end
				fend = (drain_pos + 1 >= w);
				edge_queue.push_back(sobel_magnitude(dcol[0], dcol[1], dcol[2], fend));
				if (fend) begin
					draining = 0;
					drain_pos = 0;
				end else begin
					drain_pos++;
				end
			end
		end else begin
			draining = 0;
			drain_pos = 0;
			if (col_pos >= MaxWidth) col_pos = MaxWidth - 1;
			if (col_pos == 0) begin
				win_prev = '0;
				win_last = '0;
			end
			cur.top = (row_pos >= 2) ? older_line[col_pos] : '0;
			cur.mid = (row_pos >= 1) ? newer_line[col_pos] : '0;
			cur.bot = {it.pixel_red, it.pixel_green, it.pixel_blue};
			if (row_pos >= 1 && col_pos >= 1)
				edge_queue.push_back(sobel_magnitude(win_prev, win_last, cur, 1'b0));
			if (row_pos >= 1 && col_pos + 1 >= w)
				edge_queue.push_back(sobel_magnitude(win_last, cur, '0, 1'b0));
			win_prev = win_last;
			win_last = cur;
			older_line[col_pos] = newer_line[col_pos];
			newer_line[col_pos] = cur.bot;
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= active_height()) begin
					drain_top = (row_pos >= 2);
					row_pos = 0;
					draining = 1;
					drain_pos = 0;
				end
			end
		end
	endtask

	// one request through the push/full handshake, with bursts and gaps
	task automatic send_item(in_item_t it);
		bit taken;
		if (burst_left == 0) begin
			if (!no_gaps) begin
				push <= 1'b0;
				repeat ($urandom_range(0, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		push <= 1'b1;
		item <= it;
		do begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end while (!taken);
		burst_left--;
		sent_items++;
		predict_edges(it);
	endtask

	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		in_item_t it;
		it.command = CmdPixel;
		it.pixel_red = r;
		it.pixel_green = g;
		it.pixel_blue = b;
		send_item(it);
	endtask

	function automatic logic [7:0] random_level();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// pixel fields of a drain carry noise
	task automatic send_drain();
		in_item_t it;
		it.command = CmdDrain;
		it.pixel_red = random_level();
		it.pixel_green = random_level();
		it.pixel_blue = random_level();
		send_item(it);
	endtask

	task automatic send_random_pixel();
		send_pixel(random_level(), random_level(), random_level());
	endtask

	// wait until every expected result is out and the block has settled
	task automatic wait_idle();
		push <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (edge_queue.size() != 0);
		repeat (64) @(posedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		if (idx == RegFrameWidth) shadow_width = data[WidthW-1:0];
		else if (idx == RegFrameHeight) shadow_height = data[HeightW-1:0];
	endtask

	task automatic set_geometry(int w, int h);
		write_reg(RegFrameWidth, CfgDataW'(w));
		write_reg(RegFrameHeight, CfgDataW'(h));
	endtask

	task automatic send_frame(int pixels, int drains);
		for (int i = 0; i < pixels; i++) send_random_pixel();
		for (int i = 0; i < drains; i++) send_drain();
	endtask

	// result check: compare each popped result with the oldest expectation
	always @(negedge clk) begin
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (edge_queue.size() == 0) begin
				$error("unexpected result %h", result);
				error_count++;
			end else begin
				want = edge_queue.pop_front();
				if (result.edge_red !== want.edge_red) begin
					$error("edge_red expected %0d got %0d", want.edge_red, result.edge_red);
					error_count++;
				end
				if (result.edge_green !== want.edge_green) begin
					$error("edge_green expected %0d got %0d", want.edge_green, result.edge_green);
					error_count++;
				end
				if (result.edge_blue !== want.edge_blue) begin
					$error("edge_blue expected %0d got %0d", want.edge_blue, result.edge_blue);
					error_count++;
				end
				if (result.frame_end !== want.frame_end) begin
					$error("frame_end expected %0d got %0d", want.frame_end, result.frame_end);
					error_count++;
				end
			end
		end
	end

	// receiver: phases of steady, light and heavy stalling, plus long hold-offs
	always @(posedge clk) begin
		pop_phase <= pop_phase + 1;
		if (hold_request) begin
			hold_request = 0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			pop <= 1'b0;
		end else begin
			case (pop_phase[9:8])
				2'd0: pop <= 1'b1;
				2'd1: pop <= ($urandom_range(0, 3) != 0);
				2'd2: pop <= ($urandom_range(0, 3) == 0);
				default: pop <= pop_phase[2];
			endcase
		end
	end

	// smallest frames, extreme pixel values, and a drain with nothing pending
	task automatic test_small_frames();
		set_geometry(1, 1);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_drain();
		send_drain();
		wait_idle();
		set_geometry(3, 3);
		for (int i = 0; i < 9; i++)
			if (i % 2 == 0) send_pixel(8'd255, 8'd255, 8'd255);
			else send_pixel(8'd0, 8'd0, 8'd0);
		for (int i = 0; i < 3; i++) send_drain();
		wait_idle();
	endtask

	// a pixel during the drain drops the rest and starts a new frame
	task automatic test_drain_cut_short();
		set_geometry(4, 2);
		send_frame(8, 2);
		send_frame(8, 4);
		wait_idle();
	endtask

	// zero registers, and write data bits above the width field
	task automatic test_register_limits();
		set_geometry(0, 0);
		send_frame(1, 1);
		wait_idle();
		set_geometry(4096 + 3, 2);
		send_frame(6, 3);
		wait_idle();
	endtask

	// shrink width inside a row and height inside a frame
	task automatic test_geometry_change_in_frame();
		set_geometry(6, 5);
		send_frame(9, 0);
		wait_idle();
		write_reg(RegFrameWidth, 2);
		send_frame(3, 0);
		wait_idle();
		write_reg(RegFrameHeight, 2);
		send_frame(2, 2);
		wait_idle();
	endtask

	// receiver holds off while the sender keeps pushing
	task automatic test_backpressure();
		set_geometry(16, 4);
		no_gaps = 1;
		hold_request = 1;
		send_frame(64, 16);
		no_gaps = 0;
		wait_idle();
	endtask

	// random frames: mostly complete, some cut short, some stray drains
	task automatic test_random_frames();
		int  w;
		int  h;
		bit  settled;
		int  mode;
		settled = 1;
		while (sent_items < 1200) begin
			no_gaps = ($urandom_range(0, 5) == 0);
			if (settled && $urandom_range(0, 2) == 0) begin
				wait_idle();
				w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
				h = $urandom_range(1, 6);
				set_geometry(w, h);
			end
			w = active_width();
			h = active_height();
			for (int i = 0; i < w * h; i++) begin
				if ($urandom_range(0, 30) == 0) send_drain();
				send_random_pixel();
			end
			mode = $urandom_range(0, 9);
			if (mode == 0) begin
				send_frame(0, $urandom_range(0, w - 1));
				settled = 0;
			end else begin
				send_frame(0, w + (mode == 1));
				settled = 1;
			end
		end
		if (!settled) send_frame(0, active_width());
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		pop = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		error_count = 0;
		sent_items = 0;
		burst_left = 0;
		no_gaps = 0;
		hold_request = 0;
		hold_left = 0;
		pop_phase = 0;
		shadow_width = 640;
		shadow_height = 480;
		win_prev = '0;
		win_last = '0;
		row_pos = 0;
		col_pos = 0;
		drain_pos = 0;
		draining = 0;
		drain_top = 0;
		for (int i = 0; i < MaxWidth; i++) begin
			older_line[i] = '0;
			newer_line[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_small_frames();
		test_drain_cut_short();
		test_register_limits();
		test_geometry_change_in_frame();
		test_backpressure();
		test_random_frames();

		if (error_count == 0) begin
			$display("tb_sobel_edge_magnitude_rgb_core OK");
		end else begin
			$display("tb_sobel_edge_magnitude_rgb_core NOT OK");
		end
		$finish;
	end

endmodule
`default_nettype wire
